[rtl/core/npvl_pkg.sv]
// Shared constants and types of the nearest point vertex lookup.
// No dependencies; every other file of the block imports this package.
package npvl_pkg;

	// table and field geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int COORD_BITS    = 16;
	localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int CFG_W         = 11;
	localparam int INDEX_W       = 10;
	localparam int VERTEX_W      = 24;
	localparam int DIST_W        = 34;

	// distance datapath widths
	localparam int MAG_W = COORD_BITS + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 1;

	// register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// sweep tag that travels with each table read
	typedef struct packed {
		logic              vld;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] idx;
	} tag_t;

	// table write request
	typedef struct packed {
		logic                         en;
		logic [ADDR_W-1:0]            idx;
		logic signed [COORD_BITS-1:0] u;
		logic signed [COORD_BITS-1:0] v;
		logic [VERTEX_W-1:0]          vertex;
	} wr_t;

endpackage

[rtl/core/npvl_table.sv]
// Point table: u, v and vertex id memories with one write and one registered read port.
// Depends on npvl_pkg.
module npvl_table (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  npvl_pkg::wr_t                                 wr,
	input  npvl_pkg::tag_t                                rd_tag,
	output npvl_pkg::tag_t                                tag_s1,
	output logic signed [npvl_pkg::COORD_BITS-1:0]        u_s1,
	output logic signed [npvl_pkg::COORD_BITS-1:0]        v_s1,
	output logic [npvl_pkg::VERTEX_W-1:0]                 vertex_s1
);
	import npvl_pkg::*;

	logic signed [COORD_BITS-1:0] mem_u [TABLE_ENTRIES];
	logic signed [COORD_BITS-1:0] mem_v [TABLE_ENTRIES];
	logic [VERTEX_W-1:0]          mem_vtx [TABLE_ENTRIES];

	// write one entry per load item
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_u[wr.idx]   <= wr.u;
			mem_v[wr.idx]   <= wr.v;
			mem_vtx[wr.idx] <= wr.vertex;
		end
	end

	// read the swept entry, data registered
	always_ff @(posedge clk) begin
		u_s1      <= mem_u[rd_tag.idx];
		v_s1      <= mem_v[rd_tag.idx];
		vertex_s1 <= mem_vtx[rd_tag.idx];
	end

	// advance the tag alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= rd_tag;
		end
	end

endmodule

[rtl/core/npvl_dist.sv]
// Shared squared-distance unit: combinational difference, then magnitude, square and sum in three register stages.
// Depends on npvl_pkg.
module npvl_dist (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] query_u,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] query_v,
	input  npvl_pkg::tag_t                         tag_s1,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] u_s1,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] v_s1,
	input  logic [npvl_pkg::VERTEX_W-1:0]          vertex_s1,
	output npvl_pkg::tag_t                         tag_s4,
	output logic [npvl_pkg::SUM_W-1:0]             dist_s4,
	output logic [npvl_pkg::VERTEX_W-1:0]          vertex_s4
);
	import npvl_pkg::*;

	logic signed [MAG_W-1:0] diff_u;
	logic signed [MAG_W-1:0] diff_v;
	logic [MAG_W-1:0]        mag_u_s2;
	logic [MAG_W-1:0]        mag_v_s2;
	logic [SQ_W-1:0]         sq_u_s3;
	logic [SQ_W-1:0]         sq_v_s3;
	logic [VERTEX_W-1:0]     vertex_s2;
	logic [VERTEX_W-1:0]     vertex_s3;
	tag_t                    tag_s2;
	tag_t                    tag_s3;

	// sign-extend and subtract
	assign diff_u = MAG_W'(u_s1) - MAG_W'(query_u);
	assign diff_v = MAG_W'(v_s1) - MAG_W'(query_v);

	// stage 2 magnitudes, stage 3 squares, stage 4 sum
	always_ff @(posedge clk) begin
		mag_u_s2  <= diff_u[MAG_W-1] ? MAG_W'(-diff_u) : MAG_W'(diff_u);
		mag_v_s2  <= diff_v[MAG_W-1] ? MAG_W'(-diff_v) : MAG_W'(diff_v);
		vertex_s2 <= vertex_s1;
		sq_u_s3   <= SQ_W'(mag_u_s2) * SQ_W'(mag_u_s2);
		sq_v_s3   <= SQ_W'(mag_v_s2) * SQ_W'(mag_v_s2);
		vertex_s3 <= vertex_s2;
		dist_s4   <= SUM_W'(sq_u_s3) + SUM_W'(sq_v_s3);
		vertex_s4 <= vertex_s3;
	end

	// advance the tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

endmodule

[rtl/core/npvl_seq.sv]
// Sequencer: item intake, table writes, sweep address, running minimum and result register.
// Depends on npvl_pkg.
module npvl_seq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   operation,
	input  logic [npvl_pkg::INDEX_W-1:0]           entry_index,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] coord_u,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] coord_v,
	input  logic [npvl_pkg::VERTEX_W-1:0]          entry_vertex,
	input  logic [npvl_pkg::CFG_W-1:0]             entries_in_use,
	output npvl_pkg::wr_t                          wr,
	output npvl_pkg::tag_t                         rd_tag,
	output logic signed [npvl_pkg::COORD_BITS-1:0] query_u,
	output logic signed [npvl_pkg::COORD_BITS-1:0] query_v,
	input  npvl_pkg::tag_t                         tag_s4,
	input  logic [npvl_pkg::SUM_W-1:0]             dist_s4,
	input  logic [npvl_pkg::VERTEX_W-1:0]          vertex_s4,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   found,
	output logic [npvl_pkg::VERTEX_W-1:0]          nearest_vertex,
	output logic [npvl_pkg::INDEX_W-1:0]           nearest_index,
	output logic [npvl_pkg::DIST_W-1:0]            distance_squared
);
	import npvl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [ADDR_W-1:0]            addr_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count;
	logic                         found_q;
	logic [SUM_W-1:0]             best_dist_q;
	logic [ADDR_W-1:0]            best_idx_q;
	logic [VERTEX_W-1:0]          best_vtx_q;
	logic signed [COORD_BITS-1:0] query_u_q;
	logic signed [COORD_BITS-1:0] query_v_q;
	logic                         accept;
	logic                         at_last;
	logic                         load_out;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign query_u    = query_u_q;
	assign query_v    = query_v_q;

	// clamp the entry count to the table size
	assign count = (32'(entries_in_use) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
		: CNT_W'(entries_in_use);

	// write the table on a load item that falls inside it
	always_comb begin
		wr.en     = accept && (operation == OP_LOAD) && (32'(entry_index) < TABLE_ENTRIES);
		wr.idx    = ADDR_W'(entry_index);
		wr.u      = coord_u;
		wr.v      = coord_v;
		wr.vertex = entry_vertex;
	end

	// issue one table read per sweep cycle
	assign at_last = (CNT_W'(addr_q) + CNT_W'(1)) == count_q;
	always_comb begin
		rd_tag.vld   = (state_q == ST_SWEEP);
		rd_tag.first = (addr_q == '0);
		rd_tag.last  = at_last;
		rd_tag.idx   = addr_q;
	end

	assign load_out = (state_q == ST_DONE) && (!result_valid || !result_stall);

	// sequence: intake, sweep, drain the distance unit, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (operation == OP_QUERY)) begin
						addr_q  <= '0;
						count_q <= count;
						found_q <= (count != '0);
						state_q <= (count != '0) ? ST_SWEEP : ST_DONE;
					end
				end
				ST_SWEEP: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (at_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s4.vld && tag_s4.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the query point for the sweep
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_QUERY)) begin
			query_u_q <= coord_u;
			query_v_q <= coord_v;
		end
	end

	// keep the first strictly smallest distance
	always_ff @(posedge clk) begin
		if (tag_s4.vld && (tag_s4.first || (dist_s4 < best_dist_q))) begin
			best_dist_q <= dist_s4;
			best_idx_q  <= tag_s4.idx;
			best_vtx_q  <= vertex_s4;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_out) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found            <= found_q;
			nearest_vertex   <= found_q ? best_vtx_q : '0;
			nearest_index    <= found_q ? INDEX_W'(best_idx_q) : '0;
			distance_squared <= found_q ? DIST_W'(best_dist_q) : '0;
		end
	end

`ifndef SYNTHESIS
	a_rise_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished query");
	a_no_tag_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !tag_s4.vld)
		else $error("distance unit busy while idle");
	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s4.vld && tag_s4.last) |-> (state_q == ST_DRAIN))
		else $error("last entry arrived outside drain");
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && found_q) |-> (CNT_W'(best_idx_q) < count_q))
		else $error("nearest index beyond searched entries");
`endif

endmodule

[rtl/core/nearest_point_vertex_lookup.sv]
// Top level of the nearest point vertex lookup: register port and the block's parts.
// Depends on npvl_pkg, npvl_table, npvl_dist and npvl_seq.
//
//   channel  handshake                   payload
//   item     item_valid / item_stall     operation, entry_index, coord_u, coord_v, entry_vertex
//   result   result_valid / result_stall found, nearest_vertex, nearest_index, distance_squared
//   config   psel / penable / pready     paddr, pwrite, pwdata, prdata
//
// A load item writes its entry as it is taken. A query searches N entries (N = entries_in_use,
// clamped to the table size) through the single table read port, which feeds one distance
// unit one entry a cycle; an empty table answers without a sweep.
// Reset clears control state and entries_in_use; table contents are undefined until loaded.
// Item intake stalls during a query; a finished result waits in its register while a
// new item is taken, and the next query holds in its final state until that register frees.
module nearest_point_vertex_lookup (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   operation,
	input  logic [npvl_pkg::INDEX_W-1:0]           entry_index,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] coord_u,
	input  logic signed [npvl_pkg::COORD_BITS-1:0] coord_v,
	input  logic [npvl_pkg::VERTEX_W-1:0]          entry_vertex,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   found,
	output logic [npvl_pkg::VERTEX_W-1:0]          nearest_vertex,
	output logic [npvl_pkg::INDEX_W-1:0]           nearest_index,
	output logic [npvl_pkg::DIST_W-1:0]            distance_squared,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [npvl_pkg::PADDR_W-1:0]           paddr,
	input  logic [npvl_pkg::PDATA_W-1:0]           pwdata,
	output logic [npvl_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready
);
	import npvl_pkg::*;

	logic [CFG_W-1:0]             entries_in_use_q;
	logic                         reg_sel;
	wr_t                          wr;
	tag_t                         rd_tag;
	tag_t                         tag_s1;
	tag_t                         tag_s4;
	logic signed [COORD_BITS-1:0] u_s1;
	logic signed [COORD_BITS-1:0] v_s1;
	logic [VERTEX_W-1:0]          vertex_s1;
	logic [SUM_W-1:0]             dist_s4;
	logic [VERTEX_W-1:0]          vertex_s4;
	logic signed [COORD_BITS-1:0] query_u;
	logic signed [COORD_BITS-1:0] query_v;

	// register decode: one word at byte address 0
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE);
	assign prdata  = reg_sel ? PDATA_W'(entries_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			entries_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	npvl_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.operation        (operation),
		.entry_index      (entry_index),
		.coord_u          (coord_u),
		.coord_v          (coord_v),
		.entry_vertex     (entry_vertex),
		.entries_in_use   (entries_in_use_q),
		.wr               (wr),
		.rd_tag           (rd_tag),
		.query_u          (query_u),
		.query_v          (query_v),
		.tag_s4           (tag_s4),
		.dist_s4          (dist_s4),
		.vertex_s4        (vertex_s4),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.found            (found),
		.nearest_vertex   (nearest_vertex),
		.nearest_index    (nearest_index),
		.distance_squared (distance_squared)
	);

	npvl_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_tag    (rd_tag),
		.tag_s1    (tag_s1),
		.u_s1      (u_s1),
		.v_s1      (v_s1),
		.vertex_s1 (vertex_s1)
	);

	npvl_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.query_u   (query_u),
		.query_v   (query_v),
		.tag_s1    (tag_s1),
		.u_s1      (u_s1),
		.v_s1      (v_s1),
		.vertex_s1 (vertex_s1),
		.tag_s4    (tag_s4),
		.dist_s4   (dist_s4),
		.vertex_s4 (vertex_s4)
	);

endmodule

[sim/nearest_point_vertex_lookup_test.sv]
// Self-checking bench for nearest_point_vertex_lookup: directed table, then random phases.
// Depends on npvl_pkg and the RTL top; keeps its own table copy to predict query answers that directed rows do not fix.
module nearest_point_vertex_lookup_test;
	timeunit 1ns;
	timeprecision 1ps;
	import npvl_pkg::*;

	// longest quiet stretch: the long receiver hold plus one query over the largest table
	localparam int WATCHDOG_CYCLES = 20000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int LONG_HOLD       = 300;
	localparam int IDLE_PCT        = 16;

	typedef struct packed {
		logic                         operation;
		logic [INDEX_W-1:0]           index;
		logic signed [COORD_BITS-1:0] u;
		logic signed [COORD_BITS-1:0] v;
		logic [VERTEX_W-1:0]          vertex;
	} item_t;

	typedef struct packed {
		logic                found;
		logic [VERTEX_W-1:0] vertex;
		logic [INDEX_W-1:0]  index;
		logic [DIST_W-1:0]   sq_dist;
	} answer_t;

	typedef enum {ROW_ITEM, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		item_t       item;
		bit          fixed;
		answer_t     answer;
		int unsigned count;
	} row_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_stall;
	logic                         operation;
	logic [INDEX_W-1:0]           entry_index;
	logic signed [COORD_BITS-1:0] coord_u;
	logic signed [COORD_BITS-1:0] coord_v;
	logic [VERTEX_W-1:0]          entry_vertex;
	logic                         result_valid;
	logic                         result_stall;
	logic                         found;
	logic [VERTEX_W-1:0]          nearest_vertex;
	logic [INDEX_W-1:0]           nearest_index;
	logic [DIST_W-1:0]            distance_squared;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [PADDR_W-1:0]           paddr;
	logic [PDATA_W-1:0]           pwdata;
	logic [PDATA_W-1:0]           prdata;
	logic                         pready;

	// shadow copy of the point table and the search count
	logic signed [COORD_BITS-1:0] shadow_u [TABLE_ENTRIES];
	logic signed [COORD_BITS-1:0] shadow_v [TABLE_ENTRIES];
	logic [VERTEX_W-1:0]          shadow_vertex [TABLE_ENTRIES];
	bit                           shadow_loaded [TABLE_ENTRIES];
	logic [CFG_W-1:0]             shadow_count = '0;

	answer_t     pending_answers [$];
	row_t        directed_rows [$];
	int          errors = 0;
	int          results_seen = 0;
	int          load_count = 0;
	int          query_count = 0;
	int          size_writes = 0;
	int          send_idle_pct = IDLE_PCT;
	int          recv_stall_pct = IDLE_PCT;
	int          hold_left = 0;
	int unsigned phase_sizes [8] = '{1, 2, 6, 31, 128, 200, 5, 12};

	nearest_point_vertex_lookup dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// squared distance search over the first entries_in_use points, first minimum wins
	function automatic answer_t search_nearest(logic signed [COORD_BITS-1:0] qu,
			logic signed [COORD_BITS-1:0] qv);
		answer_t         ans;
		int unsigned     span;
		int unsigned     best_j;
		longint          du;
		longint          dv;
		longint unsigned sq_dist;
		longint unsigned best;
		ans = '0;
		best = 0;
		best_j = 0;
		span = (shadow_count > TABLE_ENTRIES) ? TABLE_ENTRIES : shadow_count;
		if (span == 0)
			return ans;
		for (int unsigned j = 0; j < span; j++) begin
			du = longint'(shadow_u[j]) - longint'(qu);
			dv = longint'(shadow_v[j]) - longint'(qv);
			sq_dist = du * du + dv * dv;
			if (j == 0 || sq_dist < best) begin
				best = sq_dist;
				best_j = j;
			end
		end
		ans.found = 1'b1;
		ans.vertex = shadow_vertex[best_j];
		ans.index = best_j[INDEX_W-1:0];
		ans.sq_dist = best[DIST_W-1:0];
		return ans;
	endfunction

	// coordinate near a reference point, small, anywhere, or at an extreme
	function automatic logic signed [COORD_BITS-1:0] pick_coord(int mode,
			logic signed [COORD_BITS-1:0] near);
		logic signed [COORD_BITS-1:0] jitter;
		jitter = COORD_BITS'($urandom_range(2)) - COORD_BITS'(1);
		case (mode)
			0: return near + jitter;
			1: return COORD_BITS'($urandom_range(8)) - COORD_BITS'(4);
			2: return COORD_BITS'($urandom);
			default: begin
				case ($urandom_range(3))
					0: return {1'b1, {(COORD_BITS-1){1'b0}}};
					1: return {1'b0, {(COORD_BITS-1){1'b1}}};
					2: return '1;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	// random load or query; many points land on or next to searched entries to force ties
	function automatic item_t random_item(int unsigned span);
		item_t       it;
		int unsigned ref_j;
		int          mode;
		ref_j = $urandom_range(span - 1);
		mode = $urandom_range(3);
		it.operation = $urandom_range(1) ? OP_QUERY : OP_LOAD;
		it.index = ($urandom_range(2) == 0) ? ref_j[INDEX_W-1:0] : INDEX_W'($urandom);
		it.u = pick_coord(mode, shadow_u[ref_j]);
		it.v = pick_coord(mode, shadow_v[ref_j]);
		it.vertex = VERTEX_W'($urandom);
		return it;
	endfunction

	function automatic void add_row(logic op, int unsigned idx, int u, int v,
			int unsigned vert, bit fixed = 1'b0, logic f = 1'b0, int unsigned vtx = 0,
			int unsigned index = 0, longint unsigned sq_dist = 0);
		row_t r;
		r.kind = ROW_ITEM;
		r.item.operation = op;
		r.item.index = idx[INDEX_W-1:0];
		r.item.u = u[COORD_BITS-1:0];
		r.item.v = v[COORD_BITS-1:0];
		r.item.vertex = vert[VERTEX_W-1:0];
		r.fixed = fixed;
		r.answer.found = f;
		r.answer.vertex = vtx[VERTEX_W-1:0];
		r.answer.index = index[INDEX_W-1:0];
		r.answer.sq_dist = sq_dist[DIST_W-1:0];
		r.count = 0;
		directed_rows = {directed_rows, r};
	endfunction

	function automatic void add_count_row(int unsigned n);
		row_t r;
		r.kind = ROW_COUNT;
		r.item = '0;
		r.fixed = 1'b0;
		r.answer = '0;
		r.count = n;
		directed_rows = {directed_rows, r};
	endfunction

	// offer one item, hold it until taken, then update the shadow table or queue the answer
	task automatic send_item(input item_t it, input bit fixed, input answer_t answer);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		operation <= it.operation;
		entry_index <= it.index;
		coord_u <= it.u;
		coord_v <= it.v;
		entry_vertex <= it.vertex;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		if (it.operation == OP_LOAD) begin
			shadow_u[it.index] = it.u;
			shadow_v[it.index] = it.v;
			shadow_vertex[it.index] = it.vertex;
			shadow_loaded[it.index] = 1'b1;
			load_count++;
		end else begin
			pending_answers = {pending_answers, fixed ? answer : search_nearest(it.u, it.v)};
			query_count++;
		end
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding answer
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_answers.size() != 0);
	endtask

	// write entries_in_use while idle and read it back
	task automatic set_table_size(int unsigned n);
		logic [CFG_W-1:0] want;
		want = n[CFG_W-1:0];
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ENTRIES_IN_USE, 2'b00};
		pwdata <= PDATA_W'(want);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		shadow_count = want;
		size_writes++;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata[CFG_W-1:0] !== want) begin
			$display("%0t ns: entries_in_use readback mismatch, expected %0d, got %0d",
				$time, want, prdata[CFG_W-1:0]);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// load every entry below span that has never been written
	task automatic fill_table(int unsigned span);
		item_t it;
		for (int unsigned j = 0; j < span; j++) begin
			if (!shadow_loaded[j]) begin
				it.operation = OP_LOAD;
				it.index = j[INDEX_W-1:0];
				it.u = pick_coord($urandom_range(1, 3), '0);
				it.v = pick_coord($urandom_range(1, 3), '0);
				it.vertex = VERTEX_W'($urandom);
				send_item(it, 1'b0, '0);
			end
		end
	endtask

	task automatic compare_field(string field, logic [DIST_W-1:0] want,
			logic [DIST_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
			errors++;
		end
	endtask

	// receiver stall: long hold when requested, otherwise random
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// check each taken result against the oldest outstanding answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got found=%0b vertex=0x%0h",
					$time, found, nearest_vertex);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				compare_field("found", DIST_W'(want.found), DIST_W'(found));
				compare_field("nearest_vertex", DIST_W'(want.vertex), DIST_W'(nearest_vertex));
				compare_field("nearest_index", DIST_W'(want.index), DIST_W'(nearest_index));
				compare_field("distance_squared", want.sq_dist, distance_squared);
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((item_valid === 1'b1 && item_stall === 1'b0) ||
					(result_valid === 1'b1 && result_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog expired at %0t ns with %0d answers outstanding", $time,
			pending_answers.size());
		$display("FAIL nearest_point_vertex_lookup");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned span;
		int unsigned items;
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = OP_LOAD;
		entry_index = '0;
		coord_u = '0;
		coord_v = '0;
		entry_vertex = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, extreme points, ties, overwrite, then empty again
		add_row(OP_QUERY, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(OP_QUERY, 1023, -32768, 32767, 'hFFFFFF, 1, 0, 0, 0, 0);
		add_row(OP_LOAD, 0, -32768, -32768, 'hFFFFFF);
		add_row(OP_LOAD, 1, 32767, 32767, 1);
		add_row(OP_LOAD, 2, -32768, -32768, 'h123456);
		add_row(OP_LOAD, 3, 0, 0, 0);
		add_count_row(1);
		add_row(OP_QUERY, 0, 32767, 32767, 0, 1, 1, 'hFFFFFF, 0, 34'd8589672450);
		add_row(OP_QUERY, 0, -32768, -32768, 0, 1, 1, 'hFFFFFF, 0, 0);
		add_count_row(3);
		add_row(OP_QUERY, 0, -32768, -32768, 0, 1, 1, 'hFFFFFF, 0, 0);
		add_row(OP_QUERY, 0, 32767, 32767, 0, 1, 1, 1, 1, 0);
		add_row(OP_QUERY, 0, -32768, 32767, 0, 1, 1, 'hFFFFFF, 0, 34'd4294836225);
		add_count_row(4);
		add_row(OP_QUERY, 5, 1, -1, 7);
		add_row(OP_LOAD, 1023, 5, -5, 'hABCDEF);
		add_row(OP_LOAD, 3, 100, -100, 'hFFF);
		add_row(OP_QUERY, 0, 100, -100, 0, 1, 1, 'hFFF, 3, 0);
		add_row(OP_QUERY, 0, 0, 0, 0);
		add_count_row(0);
		add_row(OP_QUERY, 0, 7, 7, 0, 1, 0, 0, 0, 0);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_COUNT)
				set_table_size(directed_rows[r].count);
			else
				send_item(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].answer);
		end

		// random phases over several table sizes
		foreach (phase_sizes[p]) begin
			n = phase_sizes[p];
			span = (n > TABLE_ENTRIES) ? TABLE_ENTRIES : n;
			fill_table(span);
			set_table_size(n);
			send_idle_pct = (p == 4) ? 0 : IDLE_PCT;
			recv_stall_pct = (p == 4) ? 0 : IDLE_PCT;
			if (p == 3)
				hold_left = LONG_HOLD;
			items = 45;
			for (int unsigned k = 0; k < items; k++) begin
				if (p == 2 && k == items / 2)
					wait_drained();
				send_item(random_item(span), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		$display("Checked %0d query results over %0d loads and %0d table-size writes (0 to 200).",
			results_seen, load_count, size_writes);
		$display("Included a %0d-cycle receiver hold, a mid-run drain and a no-idle phase.",
			LONG_HOLD);
		if (errors == 0 && pending_answers.size() == 0)
			$display("PASS nearest_point_vertex_lookup");
		else
			$display("FAIL nearest_point_vertex_lookup");
		$finish;
	end

endmodule
